>>> src/srf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sliding rank filter
package srf_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int DATA_W         = 16;
    localparam int WS_W           = 5;
    localparam int RANK_W         = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_RANK        = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

endpackage

>>> src/srf_cell.sv
`timescale 1ns / 1ps
// one window entry with its travelling copy and stable-rank counter
module srf_cell #(
    parameter int WINDOW_MAX = 16,
    parameter int CELL_IDX   = 0,
    localparam int PW        = $clog2(WINDOW_MAX),
    localparam int NW        = $clog2(WINDOW_MAX + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srf_pkg::t_cell_ctrl i_ctrl,
    input  srf_pkg::t_sample   i_sample,
    input  logic [PW-1:0]      i_wr_pos,
    input  logic [NW-1:0]      i_n_act,
    input  logic [PW-1:0]      i_rank,
    input  srf_pkg::t_sample   i_trav,
    input  logic [PW-1:0]      i_tag,
    output srf_pkg::t_sample   o_trav,
    output logic [PW-1:0]      o_tag,
    output srf_pkg::t_sample   o_sel
);
    import srf_pkg::*;

    t_sample       r_home;
    t_sample       r_trav;
    logic [PW-1:0] r_tag;
    logic [PW-1:0] r_cnt;

    logic w_wr;
    logic w_tag_in;
    logic w_before;
    logic w_active;

    assign w_wr     = i_ctrl.load && (i_wr_pos == PW'(CELL_IDX));
    assign w_tag_in = NW'(r_tag) < i_n_act;
    // ties are broken by index, as a stable sort would place them
    assign w_before = (r_trav < r_home) ||
                      ((r_trav == r_home) && (r_tag < PW'(CELL_IDX)));
    assign w_active = NW'(CELL_IDX) < i_n_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home <= '0;
        end else if (w_wr) begin
            r_home <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_trav <= w_wr ? i_sample : r_home;
            r_tag  <= PW'(CELL_IDX);
            r_cnt  <= '0;
        end else if (i_ctrl.step) begin
            if (w_tag_in && w_before) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_trav <= i_trav;
            r_tag  <= i_tag;
        end
    end

    assign o_trav = r_trav;
    assign o_tag  = r_tag;
    assign o_sel  = (w_active && (r_cnt == i_rank)) ? r_home : '0;

endmodule

>>> src/sliding_rank_filter.sv
`timescale 1ns / 1ps
// sliding-window rank-order filter: an accepted item is written into its cell, the copies of
// the window circulate once round the ring of cells in ST_RUN, one hop per step, and ST_DONE
// loads the result into the output register once it is free; no new item is taken until then
// synchronous active-low reset clears the window to zeros, the write position to zero,
// window size to 5 and rank to 2; the block takes items in the cycle after reset
module sliding_rank_filter #(
    parameter int WINDOW_MAX = srf_pkg::WINDOW_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [srf_pkg::DATA_W-1:0]    i_s_axis_tdata,   // [15:0] sample
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [srf_pkg::DATA_W-1:0]    o_m_axis_tdata,   // [15:0] selected
    input  logic                          i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srf_pkg::*;

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int NW = $clog2(WINDOW_MAX + 1);

    logic [WS_W-1:0]   r_window_size;
    logic [RANK_W-1:0] r_rank;
    logic [PW-1:0]     r_wr_pos;
    logic [PW-1:0]     r_step;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_sample           r_out_data;

    logic [NW-1:0] w_n_act;
    logic [PW-1:0] w_rank;
    logic          w_accept;
    logic          w_out_free;
    t_cell_ctrl    w_ctrl;
    t_sample       w_sel_or;

    t_sample       w_trav [WINDOW_MAX];
    logic [PW-1:0] w_tag  [WINDOW_MAX];
    t_sample       w_sel  [WINDOW_MAX];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_W'(5);
            r_rank        <= RANK_W'(2);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WS_W-1:0];
                CFG_RANK:        r_rank        <= i_cfg_data[RANK_W-1:0];
                default:         ;
            endcase
        end
    end

    // active window size and clamped rank
    always_comb begin
        if (r_window_size == '0) begin
            w_n_act = NW'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w_n_act = NW'(WINDOW_MAX);
        end else begin
            w_n_act = NW'(r_window_size);
        end
        if (32'(r_rank) >= 32'(w_n_act)) begin
            w_rank = PW'(w_n_act - 1'b1);
        end else begin
            w_rank = PW'(r_rank);
        end
    end

    assign w_accept        = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_ctrl.load     = w_accept;
    assign w_ctrl.step     = (r_state == ST_RUN);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_RUN;
            ST_RUN:  if (r_step == PW'(WINDOW_MAX - 1)) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wr_pos <= '0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
                // wraps also when the window was shrunk below the write position
                if (32'(r_wr_pos) + 32'd1 >= 32'(w_n_act)) begin
                    r_wr_pos <= '0;
                end else begin
                    r_wr_pos <= r_wr_pos + 1'b1;
                end
            end else if (r_state == ST_RUN) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // ring of cells, each copy moves one cell along per step
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        localparam int PREV = (g + WINDOW_MAX - 1) % WINDOW_MAX;
        srf_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_sample (t_sample'(i_s_axis_tdata)),
            .i_wr_pos (r_wr_pos),
            .i_n_act  (w_n_act),
            .i_rank   (w_rank),
            .i_trav   (w_trav[PREV]),
            .i_tag    (w_tag[PREV]),
            .o_trav   (w_trav[g]),
            .o_tag    (w_tag[g]),
            .o_sel    (w_sel[g])
        );
    end

    // exactly one active cell holds the wanted rank, the rest give zero
    always_comb begin
        w_sel_or = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_sel_or = w_sel_or | w_sel[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_data <= w_sel_or;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> tb/srf_checker.sv
`timescale 1ns / 1ps
// rank filter checker: watches both streams and the config port, predicts and compares
module srf_checker #(
    parameter int WINDOW_MAX = srf_pkg::WINDOW_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [srf_pkg::DATA_W-1:0]     i_in_data,    // [15:0] sample
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [srf_pkg::DATA_W-1:0]     i_out_data,   // [15:0] selected
    input  logic                           i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);
    import srf_pkg::*;

    t_sample win_mem [WINDOW_MAX];
    int      wr_pos;
    int      size_reg;
    int      rank_reg;
    t_sample selected_q [$];
    int      mismatches = 0;

    // value at rank r among the first n entries: the entry with at most r smaller
    // entries and more than r entries not above it
    function automatic t_sample ranked_pick(input int n, input int r);
        int below;
        int not_above;
        for (int i = 0; i < n; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < n; j++) begin
                if (win_mem[j] < win_mem[i])
                    below++;
                if (win_mem[j] <= win_mem[i])
                    not_above++;
            end
            if (below <= r && r < not_above)
                return win_mem[i];
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin : track
        int      n;
        int      r;
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_MAX; i++)
                win_mem[i] = '0;
            wr_pos   = 0;
            size_reg = 5;
            rank_reg = 2;
            selected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (selected_q.size() == 0) begin
                    $error("selected: expected nothing, actual %0d", got);
                    mismatches++;
                end else begin
                    want = selected_q.pop_front();
                    if (got !== want) begin
                        $error("selected: expected %0d, actual %0d", want, got);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_WINDOW_SIZE)
                    size_reg = i_cfg_data[WS_W-1:0];
                else if (t_cfg_idx'(i_cfg_idx) == CFG_RANK)
                    rank_reg = i_cfg_data[RANK_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                n = size_reg;
                if (n == 0)
                    n = 1;
                if (n > WINDOW_MAX)
                    n = WINDOW_MAX;
                // a shrunk window may leave the position past its end: write there, then wrap
                if (wr_pos >= WINDOW_MAX)
                    wr_pos = 0;
                win_mem[wr_pos] = i_in_data;
                wr_pos = (wr_pos + 1 >= n) ? 0 : wr_pos + 1;
                r = (rank_reg >= n) ? n - 1 : rank_reg;
                selected_q.push_back(ranked_pick(n, r));
            end
        end
        o_pending    <= selected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// rank filter testbench top: clock, reset, stimulus, sink and verdict
module testbench;
    import srf_pkg::*;

    localparam int WMAX         = WINDOW_MAX_DEF;
    localparam int LATENCY      = WMAX + 2;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_STALL   = 400;
    localparam int SIZE_TOP     = 2**CFG_DATA_W - 1;
    localparam int RANK_TOP     = 2**RANK_W - 1;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic [DATA_W-1:0]     s_data  = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DATA_W-1:0]     m_data;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = CFG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic quiet           = 1'b0;
    logic long_stall_req  = 1'b0;
    logic long_stall_done = 1'b0;
    int   sink_hold       = 0;
    int   results_due;
    int   fail_count;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sliding_rank_filter #(
        .WINDOW_MAX (WMAX)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    srf_checker #(
        .WINDOW_MAX (WMAX)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (results_due),
        .o_fail_count (fail_count)
    );

    // result sink: short random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (sink_hold != 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_ready         <= 1'b0;
            sink_hold       <= LONG_STALL - 1;
            long_stall_done <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_ready   <= 1'b0;
            sink_hold <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [DATA_W-1:0] value);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    // stop offering items until every predicted result has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apply_config(input int window_size, input int rank_sel);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW_SIZE;
        cfg_data <= window_size[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_idx  <= CFG_RANK;
        cfg_data <= rank_sel[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_window();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(WMAX + 1, SIZE_TOP);
            2:       return 1;
            3:       return WMAX;
            default: return $urandom_range(2, WMAX - 1);
        endcase
    endfunction

    // mix of full-range values, extremes and a narrow band that gives many ties
    function automatic logic [DATA_W-1:0] rand_sample();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7fff;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hffff;
                endcase
            end
            2, 3, 4: v = DATA_W'(int'($urandom_range(0, 8)) - 4);
            default: v = DATA_W'($urandom());
        endcase
        return v;
    endfunction

    initial begin : stimulus
        int sent;
        int phase_len;
        int ws;
        int rk;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, so the cleared zeros take part in the ranking
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        // widest window, top rank
        apply_config(WMAX, RANK_TOP);
        for (int k = 0; k < 10; k++)
            send_sample(k[0] ? ((k & 2) ? 16'h5555 : 16'h8000) : ((k & 2) ? 16'haaaa : 16'h7fff));
        // shrink the window below the write position
        apply_config(3, 1);
        send_sample(16'h0001);
        send_sample(16'h8001);
        send_sample(16'h7ffe);
        // zero size acts as a single entry
        apply_config(0, 0);
        send_sample(16'h1234);
        send_sample(16'hfedc);
        // oversized window saturates
        apply_config(SIZE_TOP, 7);
        send_sample(16'h0100);
        send_sample(16'hff00);
        send_sample(16'h0000);
        // rank beyond the window clamps to the largest entry
        apply_config(4, 9);
        send_sample(16'hc000);
        send_sample(16'h4000);
        send_sample(16'hffff);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            ws = pick_window();
            rk = $urandom_range(0, RANK_TOP);
            if ($urandom_range(0, 2) == 0 && ws >= 1 && ws <= WMAX)
                rk = (ws - 1) / 2;
            apply_config(ws, rk);
            phase_len = $urandom_range(8, 60);
            if (!long_stall_req && sent >= 300) begin
                long_stall_req <= 1'b1;
                phase_len = 60;
            end
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (sent == 700)
                    settle();
                if (sent == RANDOM_ITEMS - QUIET_TAIL)
                    quiet <= 1'b1;
                send_sample(rand_sample());
                sent++;
            end
        end

        settle();
        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
